// ===== hdl/oid_dotted_decimal_parser_core_macros.svh =====
// Assertion macros shared by the parser RTL.
// Each check is sampled on the rising edge of clk and is held off during reset.
`ifndef OID_DOTTED_DECIMAL_PARSER_CORE_MACROS_SVH
`define OID_DOTTED_DECIMAL_PARSER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define OID_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("oid parser check failed");

// Next-cycle implication
`define OID_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("oid parser check failed");

`else

`define OID_ASSERT_IMPL(lbl, a, b)
`define OID_ASSERT_NEXT(lbl, a, b)

`endif

`endif

// ===== hdl/oid_pkg.sv =====
package oid_pkg;

    // Largest number of sub-identifiers in one text (1..128; component_index is 7 bits)
    localparam int MAX_COMPONENTS = 128;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COMPONENTS);

    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // One input request
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } oid_item_t;

    // One result request
    typedef struct packed {
        logic               component_valid;
        logic [VALUE_W-1:0] component_value;
        logic [INDEX_W-1:0] component_index;
        logic               text_done;
        logic               text_error;
    } oid_result_t;

endpackage

// ===== hdl/oid_in_reg.sv =====
module oid_in_reg
    import oid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  oid_item_t in_item,
    input  logic      take,
    output logic      item_valid,
    output oid_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    oid_item_t item_reg;

    // Refill in the same cycle the held request is consumed
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/oid_step.sv =====
`include "oid_dotted_decimal_parser_core_macros.svh"

module oid_step
    import oid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  oid_item_t   item,
    input  logic        take,
    output logic        has_result,
    output oid_result_t result
);

    logic               at_start_reg,  at_start_next;
    logic [VALUE_W-1:0] accum_reg,     accum_next;
    logic               ovf_reg,       ovf_next;
    logic               has_digit_reg, has_digit_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               error_reg,     error_next;

    logic               is_dot;
    logic               is_digit;
    logic               last;
    logic [3:0]         digit;
    logic [VALUE_W+3:0] times_ten;
    logic               good;
    logic               emit;

    // Character decode and accumulate step: accum * 10 + digit
    assign is_dot   = (item.char_code == CH_DOT);
    assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    assign last     = item.end_of_text;
    assign digit    = 4'(item.char_code - CH_ZERO);
    assign times_ten = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {(VALUE_W)'(0), digit};

    // Next state and result for the held character
    always_comb
    begin
        at_start_next  = 1'b0;
        accum_next     = accum_reg;
        ovf_next       = ovf_reg;
        has_digit_next = has_digit_reg;
        count_next     = count_reg;
        error_next     = error_reg;
        good           = 1'b0;
        emit           = 1'b0;
        result         = '0;

        if (at_start_reg && is_dot)
        begin
            // leading dot skipped; alone it is an empty text
            if (last)
                error_next = 1'b1;
        end
        else if (is_digit || is_dot)
        begin
            if (is_digit)
            begin
                has_digit_next = 1'b1;
                if (!ovf_reg)
                begin
                    if (|times_ten[VALUE_W+3:VALUE_W])
                        ovf_next = 1'b1;
                    else
                        accum_next = times_ten[VALUE_W-1:0];
                end
            end
            // a dot, or a digit that ends the text, closes the component
            if (is_dot || last)
            begin
                good = has_digit_next && !ovf_next && (count_reg < MAX_COUNT);
                if (!good)
                    error_next = 1'b1;
                else if (!error_reg)
                begin
                    emit                   = 1'b1;
                    result.component_value = accum_next;
                    result.component_index = count_reg[INDEX_W-1:0];
                    count_next             = count_reg + 1'b1;
                end
                accum_next     = '0;
                ovf_next       = 1'b0;
                has_digit_next = 1'b0;
                // final dot leaves an empty component
                if (is_dot && last)
                    error_next = 1'b1;
            end
        end
        else
        begin
            // any other character
            error_next     = 1'b1;
            accum_next     = '0;
            ovf_next       = 1'b0;
            has_digit_next = 1'b0;
        end

        result.component_valid = emit;
        result.text_done       = last;
        result.text_error      = last && error_next;
        has_result             = emit || last;

        // end of text returns everything to the idle values
        if (last)
        begin
            at_start_next  = 1'b1;
            accum_next     = '0;
            ovf_next       = 1'b0;
            has_digit_next = 1'b0;
            count_next     = '0;
            error_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg  <= 1'b1;
            accum_reg     <= '0;
            ovf_reg       <= 1'b0;
            has_digit_reg <= 1'b0;
            count_reg     <= '0;
            error_reg     <= 1'b0;
        end
        else if (take)
        begin
            at_start_reg  <= at_start_next;
            accum_reg     <= accum_next;
            ovf_reg       <= ovf_next;
            has_digit_reg <= has_digit_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
        end
    end

    `OID_ASSERT_IMPL(a_count_in_range, 1'b1, count_reg <= MAX_COUNT)
    `OID_ASSERT_IMPL(a_no_emit_after_error, error_reg, !emit)
    `OID_ASSERT_NEXT(a_restart_after_end, take && last,
                     at_start_reg && (count_reg == '0) && !error_reg)

endmodule

// ===== hdl/oid_out_reg.sv =====
module oid_out_reg
    import oid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  oid_result_t load_result,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output oid_result_t out_result
);

    logic        valid_reg;
    logic        valid_next;
    oid_result_t result_reg;

    // Slot is free when empty or emptied this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= load_result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== hdl/oid_dotted_decimal_parser_core.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_ready    char_code[7:0], end_of_text
// result    out_valid/out_ready  component_valid, component_value[31:0],
//                                component_index[6:0], text_done, text_error
//
// One character per cycle sustained while results are taken; each character
// passes through the input register, then the step logic, to the result register.
// The step logic is one multiply-by-ten add and a range check per character.
// rst_n clears valid and parser state at once; the next character starts a new text.
// A stalled result stops only characters that produce a result.
`include "oid_dotted_decimal_parser_core_macros.svh"

module oid_dotted_decimal_parser_core
    import oid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               component_valid,
    output logic [VALUE_W-1:0] component_value,
    output logic [INDEX_W-1:0] component_index,
    output logic               text_done,
    output logic               text_error
);

    oid_item_t   in_item;
    oid_item_t   item;
    logic        item_valid;
    logic        take;
    logic        has_result;
    logic        out_free;
    oid_result_t step_result;
    oid_result_t out_result;

    assign in_item.char_code   = char_code;
    assign in_item.end_of_text = end_of_text;

    // Consume the held character unless its result has nowhere to go
    assign take = item_valid && (!has_result || out_free);

    oid_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    oid_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .has_result (has_result),
        .result     (step_result)
    );

    oid_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && has_result),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign component_valid = out_result.component_valid;
    assign component_value = out_result.component_value;
    assign component_index = out_result.component_index;
    assign text_done       = out_result.text_done;
    assign text_error      = out_result.text_error;

    `OID_ASSERT_IMPL(a_error_only_when_done, out_valid && text_error, text_done)
    `OID_ASSERT_IMPL(a_empty_fields_zero, out_valid && !component_valid,
                     (component_value == '0) && (component_index == '0))
    `OID_ASSERT_IMPL(a_result_has_content, out_valid, component_valid || text_done)
    `OID_ASSERT_NEXT(a_load_shows_result, take && has_result, out_valid)

endmodule

// ===== tb/oid_dotted_decimal_parser_core_test.sv =====
module oid_dotted_decimal_parser_core_test;

    import oid_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CHAR_W-1:0]  char_code = '0;
    logic               end_of_text = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               component_valid;
    logic [VALUE_W-1:0] component_value;
    logic [INDEX_W-1:0] component_index;
    logic               text_done;
    logic               text_error;

    oid_dotted_decimal_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .component_valid (component_valid),
        .component_value (component_value),
        .component_index (component_index),
        .text_done       (text_done),
        .text_error      (text_error)
    );

    // Character stream waiting to be sent, and text under construction
    oid_item_t          char_stream[$];
    logic [CHAR_W-1:0]  text_buf[$];
    oid_result_t        expected_results[$];

    // Parser state mirrored by the predictor
    logic               text_start = 1'b1;
    logic [VALUE_W-1:0] acc_value = '0;
    logic               acc_overflow = 1'b0;
    logic               got_digit = 1'b0;
    logic [COUNT_W-1:0] comp_count = '0;
    logic               text_bad = 1'b0;

    int fail_count = 0;
    int texts_built = 0;
    int total_chars = 0;
    int chars_accepted = 0;
    int results_checked = 0;
    int components_seen = 0;
    int bad_texts_seen = 0;

    // Sender burst control
    int          burst_left = 1;
    int          gap_left = 0;
    oid_item_t   send_item;

    // Receiver stall control
    int          cycle_count = 0;
    int          hold_left = 0;
    logic        long_hold_done = 1'b0;
    logic [7:0]  ready_mask = 8'b1011_0110;
    oid_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the result, if any, that one accepted character produces
    function automatic void predict_char(input logic [CHAR_W-1:0] c, input logic last);
        logic        was_start;
        logic        closing;
        logic        final_dot;
        logic        emit;
        logic [63:0] next_val;
        oid_result_t r;
        was_start = text_start;
        text_start = 1'b0;
        closing = 1'b0;
        final_dot = 1'b0;
        emit = 1'b0;
        r = '0;
        if (was_start && c == CH_DOT)
        begin
            // skipped leading dot; alone it leaves an empty text
            if (last)
                text_bad = 1'b1;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            got_digit = 1'b1;
            if (!acc_overflow)
            begin
                next_val = {32'd0, acc_value} * 64'd10 + 64'(c - CH_ZERO);
                if (next_val > 64'hFFFF_FFFF)
                    acc_overflow = 1'b1;
                else
                    acc_value = next_val[31:0];
            end
            closing = last;
        end
        else if (c == CH_DOT)
        begin
            closing = 1'b1;
            final_dot = last;
        end
        else
        begin
            text_bad = 1'b1;
            acc_value = '0;
            acc_overflow = 1'b0;
            got_digit = 1'b0;
        end

        // complete the current component
        if (closing)
        begin
            if (!got_digit || acc_overflow || comp_count >= MAX_COMPONENTS)
                text_bad = 1'b1;
            else if (!text_bad)
            begin
                emit = 1'b1;
                r.component_value = acc_value;
                r.component_index = comp_count[INDEX_W-1:0];
                comp_count = comp_count + 1'b1;
            end
            acc_value = '0;
            acc_overflow = 1'b0;
            got_digit = 1'b0;
        end
        if (final_dot)
            text_bad = 1'b1;

        if (emit || last)
        begin
            r.component_valid = emit;
            r.text_done = last;
            r.text_error = last && text_bad;
            expected_results.insert(expected_results.size(), r);
        end

        if (last)
        begin
            text_start = 1'b1;
            acc_value = '0;
            acc_overflow = 1'b0;
            got_digit = 1'b0;
            comp_count = '0;
            text_bad = 1'b0;
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", field, exp_val, got_val);
            fail_count++;
        end
    endfunction

    function automatic void add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
    endfunction

    // Move the text under construction into the stream, flagging its last character
    function automatic void send_text();
        oid_item_t it;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            it.char_code = text_buf[i];
            it.end_of_text = (i == text_buf.size() - 1);
            char_stream.insert(char_stream.size(), it);
        end
        text_buf.delete();
        texts_built++;
    endfunction

    // Digit string for one component, biased toward edges of the 32-bit range
    function automatic string component_digits();
        int unsigned     pick;
        longint unsigned v;
        string           s;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: v = 64'($urandom_range(0, 200));
            4, 5:       v = 64'($urandom());
            6:          v = 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
            7:          v = 64'h1_0000_0000 + 64'($urandom_range(0, 10));
            8:          v = {$urandom(), $urandom()};
            default:    v = 64'($urandom_range(0, 9));
        endcase
        s = $sformatf("%0d", v);
        // leading zeros
        if (pick == 9)
            for (int i = $urandom_range(1, 12); i > 0; i--)
                s = {"0", s};
        return s;
    endfunction

    function automatic void build_oid(input int n_comps, input logic short_vals);
        if ($urandom_range(0, 1))
            add_string(".");
        for (int i = 0; i < n_comps; i++)
        begin
            if (i > 0)
                add_string(".");
            if (short_vals)
                add_string($sformatf("%0d", $urandom_range(0, 99)));
            else
                add_string(component_digits());
        end
    endfunction

    // Driver: bursts of requests with random gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_char(char_code, end_of_text);
                chars_accepted++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the offered request
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (char_stream.size() > 0)
            begin
                send_item = char_stream.pop_front();
                char_code <= send_item.char_code;
                end_of_text <= send_item.end_of_text;
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: compare each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("component_valid", 32'(want.component_valid),
                                32'(component_valid));
                    check_field("component_value", want.component_value, component_value);
                    check_field("component_index", 32'(want.component_index),
                                32'(component_index));
                    check_field("text_done", 32'(want.text_done), 32'(text_done));
                    check_field("text_error", 32'(want.text_error), 32'(text_error));
                    if (component_valid)
                        components_seen++;
                    if (text_done && text_error)
                        bad_texts_seen++;
                end
            end

            // one long hold-off so the parser backs up into its input
            cycle_count++;
            if (!long_hold_done && results_checked >= 150)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((cycle_count / 50) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ready_mask[3'(cycle_count % 8)];
                endcase
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int drain;
        int kind;
        int pos;
        logic long_max_sent;
        logic long_over_sent;
        long_max_sent = 1'b0;
        long_over_sent = 1'b0;
        rst_n = 1'b0;

        // directed texts
        add_string(".4294967295");
        send_text();
        add_string(".");
        send_text();
        add_string("0..");
        send_text();
        add_string("9a");
        send_text();
        add_string("007");
        send_text();
        add_string("7.");
        send_text();
        text_buf.insert(text_buf.size(), 8'hFF);
        send_text();
        add_string("5");
        text_buf.insert(text_buf.size(), 8'h00);
        send_text();

        // random texts, mostly well formed
        while (char_stream.size() < 1750)
        begin
            if (!long_max_sent && char_stream.size() > 400)
            begin
                long_max_sent = 1'b1;
                build_oid(MAX_COMPONENTS, 1'b1);
            end
            else if (!long_over_sent && char_stream.size() > 1000)
            begin
                long_over_sent = 1'b1;
                build_oid(MAX_COMPONENTS + 1, 1'b1);
            end
            else
            begin
                kind = $urandom_range(0, 19);
                if (kind < 18)
                    build_oid($urandom_range(1, 8), 1'b0);
                else
                    for (int i = $urandom_range(1, 5); i > 0; i--)
                        text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                // broken sequences: corrupt a well-formed text
                if (kind >= 14 && kind < 18)
                begin
                    pos = $urandom_range(0, text_buf.size() - 1);
                    case ($urandom_range(0, 3))
                        0: text_buf[pos] = 8'($urandom_range(0, 255));
                        1: text_buf.insert(pos, CH_DOT);
                        2: text_buf.insert(text_buf.size(), CH_DOT);
                        default:
                        begin
                            text_buf.delete(pos);
                            if (text_buf.size() == 0)
                                text_buf.insert(0, 8'($urandom_range(0, 255)));
                        end
                    endcase
                end
            end
            send_text();
        end
        total_chars = char_stream.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_accepted < total_chars)
            @(posedge clk);
        drain = 0;
        while (expected_results.size() > 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            $error("%0d predicted results never arrived", expected_results.size());
            fail_count++;
        end

        $display("Sent %0d texts as %0d characters; checked %0d results.",
                 texts_built, total_chars, results_checked);
        $display("Seen %0d components and %0d malformed texts.",
                 components_seen, bad_texts_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/oid_pkg.sv
hdl/oid_in_reg.sv
hdl/oid_step.sv
hdl/oid_out_reg.sv
hdl/oid_dotted_decimal_parser_core.sv
tb/oid_dotted_decimal_parser_core_test.sv
